>>> src/tdl_pkg.sv
`timescale 1ns / 1ps
package tdl_pkg;

  // result kinds
  localparam logic [1:0] KIND_ECHO     = 2'd0;
  localparam logic [1:0] KIND_DATA     = 2'd1;
  localparam logic [1:0] KIND_NOTREADY = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE = 2'd1;

  // depth of the command queue between front and back
  localparam int unsigned CMDQ_DEPTH = 2;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'd0;
  localparam logic [7:0] CH_BS     = 8'd8;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_FS     = 8'd28;
  localparam logic [7:0] CH_SP     = 8'd32;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_AT     = 8'd64;
  localparam logic [7:0] CH_BSLASH = 8'd92;
  localparam logic [7:0] CH_CARET  = 8'd94;
  localparam logic [7:0] CH_DEL    = 8'd127;

  typedef enum logic [1:0] {
    OP_READ,
    OP_STORE,
    OP_ERASE
  } op_e;

  // result sequences the back end can play out
  typedef enum logic [2:0] {
    P_NONE,
    P_CHAR,
    P_CRLF,
    P_CARET,
    P_ERASE1,
    P_ERASE2,
    P_DATA,
    P_NOTREADY
  } pat_e;

  typedef struct packed {
    op_e        op;
    pat_e       pat;
    logic [7:0] ch;
  } cmd_t;

  function automatic logic [2:0] pat_len(input pat_e pat);
    logic [2:0] len;
    case (pat)
      P_CRLF:   len = 3'd2;
      P_CARET:  len = 3'd2;
      P_ERASE1: len = 3'd3;
      P_ERASE2: len = 3'd6;
      default:  len = 3'd1;
    endcase
    return len;
  endfunction

  function automatic logic [1:0] pat_kind(input pat_e pat);
    logic [1:0] k;
    case (pat)
      P_DATA:     k = KIND_DATA;
      P_NOTREADY: k = KIND_NOTREADY;
      default:    k = KIND_ECHO;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] caret_char(input logic [7:0] ch);
    logic [7:0] c;
    if (ch == CH_NUL) begin
      c = CH_ZERO;
    end else if (ch == CH_FS) begin
      c = CH_BSLASH;
    end else begin
      c = CH_AT + ch;
    end
    return c;
  endfunction

  function automatic logic [7:0] pat_byte(input pat_e pat, input logic [2:0] idx,
                                          input logic [7:0] ch);
    logic [7:0] b;
    case (pat)
      P_CHAR:   b = ch;
      P_DATA:   b = ch;
      P_CRLF:   b = (idx == 3'd0) ? CH_CR : CH_LF;
      P_CARET:  b = (idx == 3'd0) ? CH_CARET : caret_char(ch);
      P_ERASE1: b = (idx == 3'd1) ? CH_SP : CH_BS;
      P_ERASE2: b = (idx == 3'd2 || idx == 3'd3) ? CH_SP : CH_BS;
      default:  b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

>>> src/tty_line_discipline_core.sv
// a request occupies the back end from dispatch until its last result: a dispatch step,
// a buffer read step for reads and erases, then one result per cycle while the output
// register is free or being popped (up to six results)
// a new request waits until the last is done; a 2-entry command queue absorbs bursts
// reset: asynchronous active low; clears pointers, counts and queues, echo and line on
`timescale 1ns / 1ps
module tty_line_discipline_core
  import tdl_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic                 action_i,
  input  logic [7:0]           rx_byte_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [1:0]           kind_o,
  output logic [7:0]           out_byte_o,
  output logic                 last_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic                 cfg_data_i
);

  logic echo_en_q, line_en_q;
  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_en_q <= 1'b1;
      line_en_q <= 1'b1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_ECHO) begin
        echo_en_q <= cfg_data_i;
      end
      if (cfg_index_i == REG_LINE) begin
        line_en_q <= cfg_data_i;
      end
    end
  end

  tdl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .echo_en_i  (echo_en_q),
    .push_i     (push),
    .action_i   (action_i),
    .rx_byte_i  (rx_byte_i),
    .full_o     (full),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  tdl_back #(
    .Depth(FIFO_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .line_en_i  (line_en_q),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .kind_o     (kind_o),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

`ifndef SYNTHESIS
  // a not-ready answer is a single zero result
  a_notready_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_NOTREADY) |-> (out_byte_o == 8'd0 && last_o))
    else $error("not-ready result malformed");

  // delivered data always closes its read
  a_data_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_DATA) |-> last_o)
    else $error("read data not marked last");

  // after a popped non-final echo, the next result is an echo too
  a_echo_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !last_o) ##1 !empty |-> kind_o == KIND_ECHO)
    else $error("echo sequence broken");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (kind_o == KIND_ECHO || kind_o == KIND_DATA || kind_o == KIND_NOTREADY))
    else $error("illegal result kind");
`endif

endmodule

>>> src/tdl_ram.sv
`timescale 1ns / 1ps
module tdl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/tdl_front.sv
`timescale 1ns / 1ps
module tdl_front
  import tdl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       echo_en_i,
  input  logic       push_i,
  input  logic       action_i,
  input  logic [7:0] rx_byte_i,
  output logic       full_o,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  logic       cmd_pop_i
);

  localparam int unsigned QAW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(CMDQ_DEPTH + 1);

  cmd_t           q_mem [CMDQ_DEPTH];
  logic [QAW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCW-1:0] cnt_q, cnt_d;
  cmd_t           cls;
  logic [7:0]     ch;
  logic           do_push, do_pop;

  // classify the incoming request
  always_comb begin
    ch = (rx_byte_i == CH_CR) ? CH_LF : rx_byte_i;
    cls.ch  = ch;
    cls.pat = P_NONE;
    if (action_i) begin
      cls.op = OP_READ;
    end else if (!echo_en_i) begin
      cls.op = OP_STORE;
    end else if (ch == CH_BS || ch == CH_DEL) begin
      cls.op = OP_ERASE;
    end else begin
      cls.op = OP_STORE;
      if (ch == CH_LF) begin
        cls.pat = P_CRLF;
      end else if (ch < CH_SP) begin
        cls.pat = P_CARET;
      end else begin
        cls.pat = P_CHAR;
      end
    end
  end

  assign full_o      = (cnt_q == QCW'(CMDQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QAW'(CMDQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == QAW'(CMDQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_q] <= cls;
    end
  end

endmodule

>>> src/tdl_back.sv
`timescale 1ns / 1ps
module tdl_back
  import tdl_pkg::*;
#(
  parameter int unsigned Depth = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       line_en_i,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_WAIT,
    S_ER_WAIT,
    S_EMIT
  } state_e;

  state_e        state_q;
  logic [AW-1:0] rd_ptr_q, wr_ptr_q, wr_prev, rd_next, wr_next;
  logic [CW-1:0] fill_q, nl_q;
  pat_e          pat_q;
  logic [7:0]    ch_q;
  logic [2:0]    idx_q;
  logic          out_valid_q, out_last_q;
  logic [1:0]    out_kind_q;
  logic [7:0]    out_byte_q;

  logic          idle_go, deliverable, has_room, slot_free, seq_last, emit_fire;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  assign wr_prev = (wr_ptr_q == '0) ? AW'(Depth - 1) : wr_ptr_q - 1'b1;
  assign wr_next = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
  assign rd_next = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;

  assign idle_go     = (state_q == S_IDLE) && cmd_valid_i;
  assign deliverable = (fill_q != '0) && !(line_en_i && nl_q == '0);
  assign has_room    = (fill_q != CW'(Depth));
  assign cmd_pop_o   = idle_go;

  assign ram_we    = idle_go && cmd_i.op == OP_STORE && has_room;
  assign ram_re    = idle_go && ((cmd_i.op == OP_READ && deliverable) ||
                                 (cmd_i.op == OP_ERASE && fill_q != '0));
  assign ram_raddr = (cmd_i.op == OP_READ) ? rd_ptr_q : wr_prev;

  tdl_ram #(
    .Width(8),
    .Depth(Depth)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_ptr_q),
    .wdata_i(cmd_i.ch),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // output register frees up in the same cycle it is popped
  assign slot_free = !out_valid_q || pop_i;
  assign seq_last  = (idx_q == pat_len(pat_q) - 3'd1);
  assign emit_fire = (state_q == S_EMIT) && slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      fill_q      <= '0;
      nl_q        <= '0;
      pat_q       <= P_NONE;
      ch_q        <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_kind_q  <= KIND_ECHO;
      out_byte_q  <= '0;
    end else begin
      if (out_valid_q && pop_i && !emit_fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            idx_q <= '0;
            ch_q  <= cmd_i.ch;
            case (cmd_i.op)
              OP_READ: begin
                if (deliverable) begin
                  state_q <= S_RD_WAIT;
                end else begin
                  pat_q   <= P_NOTREADY;
                  state_q <= S_EMIT;
                end
              end
              OP_STORE: begin
                if (has_room) begin
                  wr_ptr_q <= wr_next;
                  fill_q   <= fill_q + 1'b1;
                  if (cmd_i.ch == CH_LF) begin
                    nl_q <= nl_q + 1'b1;
                  end
                  if (cmd_i.pat != P_NONE) begin
                    pat_q   <= cmd_i.pat;
                    state_q <= S_EMIT;
                  end
                end
              end
              OP_ERASE: begin
                if (fill_q != '0) begin
                  state_q <= S_ER_WAIT;
                end
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_RD_WAIT: begin
          ch_q     <= ram_rdata;
          pat_q    <= P_DATA;
          rd_ptr_q <= rd_next;
          fill_q   <= fill_q - 1'b1;
          if (ram_rdata == CH_LF && nl_q != '0) begin
            nl_q <= nl_q - 1'b1;
          end
          state_q <= S_EMIT;
        end
        S_ER_WAIT: begin
          // a buffered newline is never erased
          if (ram_rdata == CH_LF) begin
            state_q <= S_IDLE;
          end else begin
            wr_ptr_q <= wr_prev;
            fill_q   <= fill_q - 1'b1;
            pat_q    <= (ram_rdata < CH_SP) ? P_ERASE2 : P_ERASE1;
            state_q  <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= pat_kind(pat_q);
            out_byte_q  <= pat_byte(pat_q, idx_q, ch_q);
            out_last_q  <= seq_last;
            idx_q       <= idx_q + 3'd1;
            if (seq_last) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign empty_o    = !out_valid_q;
  assign kind_o     = out_kind_q;
  assign out_byte_o = out_byte_q;
  assign last_o     = out_last_q;

endmodule
